/* rtl/bmlcd_pkg.sv */
// Shared types and constants for the bitmap to LCD page transpose block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bmlcd_pkg;

  // One strip of the picture is eight bitmap rows; seven of them are stored.
  localparam int STRIP_ROWS = 8;
  localparam int SLOTS      = 7;

  // The LCD address is ten bits: seven bits of page line, three of column bit.
  localparam int ADDR_W = 10;
  localparam int LINE_W = 7;
  localparam int BIT_W  = 3;

  // Slot of the strip row that completes a column group.
  localparam logic [BIT_W-1:0] LAST_SLOT = 3'd7;

  typedef logic [7:0] byte_t;

  // Eight finished LCD bytes and the page line they belong to.
  typedef struct packed {
    logic [LINE_W-1:0] line;
    byte_t [7:0]       data;
  } group_t;

endpackage

`default_nettype wire

/* rtl/bmlcd_strip_store.sv */
// Storage for the first seven rows of the current strip: one bank per row.
// Depends on bmlcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmlcd_strip_store
  import bmlcd_pkg::*;
#(
  parameter int ROW_BYTES = 16,
  parameter int COL_W     = 4
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [BIT_W-1:0]    wr_slot,
  input  wire logic [COL_W-1:0]    wr_col,
  input  wire byte_t               wr_data,
  input  wire logic                rd_en,
  input  wire logic [COL_W-1:0]    rd_col,
  output byte_t [SLOTS-1:0]        rd_data
);

  // Each bank holds one row; all banks are read at the same column at once.
  for (genvar i = 0; i < SLOTS; i++) begin : g_bank
    byte_t mem [ROW_BYTES];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_slot == BIT_W'(i))) begin
        mem[wr_col] <= wr_data;
      end
      if (rd_en) begin
        rd_data[i] <= mem[rd_col];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/bmlcd_transpose.sv */
// 8x8 bit transpose: column bit f of the eight strip rows becomes LCD byte f.
// Depends on bmlcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmlcd_transpose
  import bmlcd_pkg::*;
(
  input  wire byte_t [7:0] src,
  output byte_t [7:0]      dst
);

  // Bit m of LCD byte f is the pixel of row m taken with mask 0x80 >> f.
  always_comb begin
    for (int f = 0; f < 8; f++) begin
      for (int m = 0; m < 8; m++) begin
        dst[f][m] = src[m][7-f];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/bmlcd_serializer.sv */
// Output register that hands out one column group as eight LCD byte results.
// Depends on bmlcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmlcd_serializer
  import bmlcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load_valid,
  output logic                   load_ready,
  input  wire group_t            load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      lcd_address,
  output byte_t                  lcd_byte,
  output logic                   last_of_group
);

  logic              busy;
  logic [BIT_W-1:0]  cnt;
  group_t            group;
  logic              out_take;

  assign out_take   = busy && out_ready;
  // A new group may enter while the last byte of the current one leaves.
  assign load_ready = !busy || (out_ready && (cnt == LAST_SLOT));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (out_take) begin
      if (cnt == LAST_SLOT) begin
        busy <= 1'b0;
      end
      cnt <= cnt + BIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      group <= load;
    end
  end

  // Present the current byte of the group.
  assign out_valid     = busy;
  assign lcd_byte      = group.data[cnt];
  assign lcd_address   = {group.line, cnt};
  assign last_of_group = (cnt == LAST_SLOT);

endmodule

`default_nettype wire

/* rtl/bitmap_to_lcd_page_transpose.sv */
// Top level: bitmap byte stream in, LCD page bytes with addresses out.
// Depends on bmlcd_pkg, bmlcd_strip_store, bmlcd_transpose, bmlcd_serializer.
`timescale 1ns / 1ps
`default_nettype none

// The block takes the bytes of a bottom-up 1 bit per pixel bitmap in file order,
// one request per cycle while in_ready is high, and inverts them. Bytes of the
// first seven rows of each eight-row strip are only stored (one bank per row,
// read all at once). A byte of the eighth row completes eight pixel columns: it
// is held in the stage register, then its group goes to the serializer register,
// and the eight LCD bytes of those columns leave on the result channel, one per
// cycle while out_ready is high, last_of_group marking the eighth. The single
// result channel sets the rate in the eighth row of a strip, while stalls on the
// result side hold the input only when a completing byte arrives and a group is
// still waiting. A frame is FRAME_BYTES bytes long; the position counter wraps after it.
module bitmap_to_lcd_page_transpose
  import bmlcd_pkg::*;
#(
  parameter int ROW_BYTES   = 16,
  parameter int FRAME_BYTES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        pixel_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      lcd_address,
  output logic [7:0]             lcd_byte,
  output logic                   last_of_group
);

  localparam int POS_W   = $clog2(FRAME_BYTES);
  localparam int COL_W   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int PAGES   = FRAME_BYTES / ROW_BYTES / STRIP_ROWS;
  localparam int STRIP_W = $clog2(FRAME_BYTES / ROW_BYTES / STRIP_ROWS + 2);

  // Frame position, split into column, row within the strip and strip.
  logic [POS_W-1:0]   pos;
  logic [COL_W-1:0]   col;
  logic [BIT_W-1:0]   slot;
  logic [STRIP_W-1:0] strip;

  logic               in_take;
  logic               emit;
  byte_t              inv;
  logic [STRIP_W-1:0] page;
  logic [LINE_W-1:0]  line_next;

  // Stage register for a request that completes a column group.
  logic               b_valid;
  byte_t              b_inv;
  logic [LINE_W-1:0]  b_line;
  logic               b_take;

  byte_t [SLOTS-1:0]  rd_data;
  byte_t [7:0]        src;
  byte_t [7:0]        cols;
  group_t             group;

  assign inv  = ~pixel_byte;
  assign emit = (slot == LAST_SLOT) && (strip < STRIP_W'(PAGES));
  assign page = STRIP_W'(PAGES) - STRIP_W'(1) - strip;

  // Page line of the group: page * ROW_BYTES + column, kept to seven bits.
  always_comb begin
    line_next = LINE_W'(int'(page) * ROW_BYTES + int'(col));
  end

  assign in_ready = !emit || !b_valid || b_take;
  assign in_take  = in_valid && in_ready;

  // Position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      col   <= '0;
      slot  <= '0;
      strip <= '0;
    end else if (in_take) begin
      if (pos == POS_W'(FRAME_BYTES - 1)) begin
        pos   <= '0;
        col   <= '0;
        slot  <= '0;
        strip <= '0;
      end else begin
        pos <= pos + POS_W'(1);
        if (col == COL_W'(ROW_BYTES - 1)) begin
          col  <= '0;
          slot <= slot + BIT_W'(1);
          if (slot == LAST_SLOT) begin
            strip <= strip + STRIP_W'(1);
          end
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  // Stage register control and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_take && emit) begin
      b_valid <= 1'b1;
    end else if (b_take) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      b_inv  <= inv;
      b_line <= line_next;
    end
  end

  bmlcd_strip_store #(
    .ROW_BYTES (ROW_BYTES),
    .COL_W     (COL_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_take && !(slot == LAST_SLOT)),
    .wr_slot (slot),
    .wr_col  (col),
    .wr_data (inv),
    .rd_en   (in_take && emit),
    .rd_col  (col),
    .rd_data (rd_data)
  );

  // Row m of the strip: the newest byte is row 0, stored row 6 - k is row k + 1.
  always_comb begin
    src[0] = b_inv;
    for (int m = 1; m < 8; m++) begin
      src[m] = rd_data[7-m];
    end
  end

  bmlcd_transpose u_transpose (
    .src (src),
    .dst (cols)
  );

  assign group.line = b_line;
  assign group.data = cols;

  bmlcd_serializer u_serializer (
    .clk           (clk),
    .rst           (rst),
    .load_valid    (b_valid),
    .load_ready    (b_take),
    .load          (group),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .lcd_address   (lcd_address),
    .lcd_byte      (lcd_byte),
    .last_of_group (last_of_group)
  );

endmodule

`default_nettype wire
